>>> rtl/epaper_window_flush_sequencer_macros.svh
// Assertion macros for the window flush sequencer checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef EPAPER_WINDOW_FLUSH_SEQUENCER_MACROS_SVH
`define EPAPER_WINDOW_FLUSH_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/wfs_pkg.sv
// Shared types, command codes and defaults for the window flush sequencer.
// Depends on nothing; imported by every module of the block.
package wfs_pkg;

    localparam int COORD_BITS_DEFAULT = 10;
    localparam int COUNT_BITS_DEFAULT = 17;
    localparam int QUEUE_DEPTH        = 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int THR_W  = 21;
    localparam int STEP_W = 4;

    // Controller command bytes.
    localparam logic [7:0] CMD_RAM_X_RANGE = 8'h44;
    localparam logic [7:0] CMD_RAM_Y_RANGE = 8'h45;
    localparam logic [7:0] CMD_RAM_X_PTR   = 8'h4E;
    localparam logic [7:0] CMD_RAM_Y_PTR   = 8'h4F;
    localparam logic [7:0] CMD_WRITE_RAM   = 8'h24;
    localparam logic [7:0] CMD_UPDATE_CTRL = 8'h22;
    localparam logic [7:0] CMD_ACTIVATE    = 8'h20;

    // Register reset values.
    localparam logic [7:0]       RST_REFRESH_LIMIT  = 8'd20;
    localparam logic [THR_W-1:0] RST_AREA_THRESHOLD = 21'd12000;
    localparam logic [7:0]       RST_MODE_FULL      = 8'hF7;
    localparam logic [7:0]       RST_MODE_FAST      = 8'hC7;
    localparam logic [7:0]       RST_MODE_PARTIAL   = 8'hFF;

    // Input action codes.
    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // Last step of each result run in the back end.
    localparam logic [STEP_W-1:0] STEP_BEGIN_LAST = 4'd13;
    localparam logic [STEP_W-1:0] STEP_FLUSH_LAST = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FIRST      = 4'd0;

    typedef enum logic [2:0] {
        REG_REFRESH_LIMIT  = 3'd0,
        REG_AREA_THRESHOLD = 3'd1,
        REG_MODE_FULL      = 3'd2,
        REG_MODE_FAST      = 3'd3,
        REG_MODE_PARTIAL   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]       refresh_limit;
        logic [THR_W-1:0] area_threshold;
        logic [7:0]       mode_full;
        logic [7:0]       mode_fast;
        logic [7:0]       mode_partial;
    } cfg_t;

    typedef enum logic {
        JOB_BEGIN = 1'b0,
        JOB_PIXEL = 1'b1
    } job_kind_t;

    // One classified item, with every byte already formatted for the bus.
    typedef struct packed {
        job_kind_t  kind;
        logic       finish;
        logic [7:0] x_start;
        logic [7:0] x_end;
        logic [7:0] y_start_lo;
        logic [7:0] y_start_hi;
        logic [7:0] y_end_lo;
        logic [7:0] y_end_hi;
        logic [7:0] pixel;
        logic [7:0] mode;
    } job_t;

endpackage

>>> rtl/wfs_regs.sv
// APB register file holding the refresh policy and the update-control bytes.
// Depends on wfs_pkg.
module wfs_regs
    import wfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_REFRESH_LIMIT:  cfg_next.refresh_limit  = pwdata[7:0];
                REG_AREA_THRESHOLD: cfg_next.area_threshold = pwdata[THR_W-1:0];
                REG_MODE_FULL:      cfg_next.mode_full      = pwdata[7:0];
                REG_MODE_FAST:      cfg_next.mode_fast      = pwdata[7:0];
                REG_MODE_PARTIAL:   cfg_next.mode_partial   = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_REFRESH_LIMIT:  prdata = DATA_W'(cfg_reg.refresh_limit);
            REG_AREA_THRESHOLD: prdata = DATA_W'(cfg_reg.area_threshold);
            REG_MODE_FULL:      prdata = DATA_W'(cfg_reg.mode_full);
            REG_MODE_FAST:      prdata = DATA_W'(cfg_reg.mode_fast);
            REG_MODE_PARTIAL:   prdata = DATA_W'(cfg_reg.mode_partial);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refresh_limit  <= RST_REFRESH_LIMIT;
            cfg_reg.area_threshold <= RST_AREA_THRESHOLD;
            cfg_reg.mode_full      <= RST_MODE_FULL;
            cfg_reg.mode_fast      <= RST_MODE_FAST;
            cfg_reg.mode_partial   <= RST_MODE_PARTIAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/wfs_front.sv
// Front end: accepts items, tracks the open flush and the refresh policy,
// and hands formatted jobs to the queue. Depends on wfs_pkg.
module wfs_front
    import wfs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  action,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] top_y,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] bottom_y,
    input  logic [7:0]            pixel_byte,
    input  cfg_t                  cfg,
    input  logic                  q_full,
    output logic                  push,
    output job_t                  job
);

    localparam int DIM_W  = COORD_BITS + 1;
    localparam int COL_W  = COORD_BITS - 2;
    localparam int LEN_W  = COL_W + DIM_W;
    localparam int SAT_W  = (LEN_W > COUNT_BITS) ? LEN_W : COUNT_BITS;
    localparam int AREA_W = 2 * DIM_W;
    localparam int CMP_W  = (AREA_W > THR_W) ? AREA_W : THR_W;

    logic                  calc_reg;
    logic                  calc_next;
    logic                  in_flush_reg;
    logic                  in_flush_next;
    logic [COUNT_BITS-1:0] bytes_left_reg;
    logic [COUNT_BITS-1:0] bytes_left_next;
    logic [7:0]            refresh_count_reg;
    logic [7:0]            refresh_count_next;
    logic                  large_window_reg;
    logic                  large_window_next;
    logic [DIM_W-1:0]      w_reg;
    logic [DIM_W-1:0]      w_next;
    logic [DIM_W-1:0]      h_reg;
    logic [DIM_W-1:0]      h_next;

    logic                  take;
    logic [COORD_BITS-1:0] x_end_c;
    logic [COORD_BITS-1:0] y_end_c;
    logic [DIM_W-1:0]      cols_full;
    logic [COL_W-1:0]      cols;
    logic [LEN_W-1:0]      len_full;
    logic [SAT_W-1:0]      len_ext;
    logic [AREA_W-1:0]     area;
    logic                  finish;
    logic                  full_refresh;

    assign item_ready = !calc_reg && !q_full;
    assign take       = item_valid && item_ready;

    // Reversed corners collapse to a single column or row.
    assign x_end_c = (right_x < left_x) ? left_x : right_x;
    assign y_end_c = (bottom_y < top_y) ? top_y : bottom_y;
    assign w_next  = DIM_W'(x_end_c) - DIM_W'(left_x) + DIM_W'(1);
    assign h_next  = DIM_W'(y_end_c) - DIM_W'(top_y) + DIM_W'(1);

    // Window arithmetic runs in the cycle after a begin item.
    assign cols_full = (w_reg + DIM_W'(7)) >> 3;
    assign cols      = COL_W'(cols_full);
    assign len_full  = LEN_W'(cols) * LEN_W'(h_reg);
    assign len_ext   = SAT_W'(len_full);
    assign area      = AREA_W'(w_reg) * AREA_W'(h_reg);

    assign finish       = (bytes_left_reg <= COUNT_BITS'(1));
    assign full_refresh = (refresh_count_reg >= cfg.refresh_limit);

    always_comb
    begin
        calc_next          = 1'b0;
        in_flush_next      = in_flush_reg;
        bytes_left_next    = bytes_left_reg;
        refresh_count_next = refresh_count_reg;
        large_window_next  = large_window_reg;
        push               = 1'b0;

        job            = '0;
        job.kind       = (action == ACT_BEGIN) ? JOB_BEGIN : JOB_PIXEL;
        job.finish     = finish;
        job.x_start    = 8'(left_x >> 3);
        job.x_end      = 8'(x_end_c >> 3);
        job.y_start_lo = 8'(top_y);
        job.y_start_hi = 8'(top_y >> 8);
        job.y_end_lo   = 8'(y_end_c);
        job.y_end_hi   = 8'(y_end_c >> 8);
        job.pixel      = pixel_byte;
        job.mode       = full_refresh ? cfg.mode_full
                       : (large_window_reg ? cfg.mode_fast : cfg.mode_partial);

        if (calc_reg)
        begin
            if (len_ext > SAT_W'({COUNT_BITS{1'b1}}))
            begin
                bytes_left_next = '1;
            end
            else
            begin
                bytes_left_next = COUNT_BITS'(len_ext);
            end
            large_window_next = (CMP_W'(area) > CMP_W'(cfg.area_threshold));
        end

        if (take)
        begin
            if (action == ACT_BEGIN)
            begin
                // A begin during an open flush drops the old window silently.
                push          = 1'b1;
                calc_next     = 1'b1;
                in_flush_next = 1'b1;
            end
            else if (in_flush_reg)
            begin
                push = 1'b1;
                if (bytes_left_reg != '0)
                begin
                    bytes_left_next = bytes_left_reg - COUNT_BITS'(1);
                end
                if (finish)
                begin
                    in_flush_next     = 1'b0;
                    large_window_next = 1'b0;
                    if (full_refresh)
                    begin
                        refresh_count_next = '0;
                    end
                    else if (refresh_count_reg != 8'hFF)
                    begin
                        refresh_count_next = refresh_count_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_reg          <= 1'b0;
            in_flush_reg      <= 1'b0;
            bytes_left_reg    <= '0;
            refresh_count_reg <= '0;
            large_window_reg  <= 1'b0;
        end
        else
        begin
            calc_reg          <= calc_next;
            in_flush_reg      <= in_flush_next;
            bytes_left_reg    <= bytes_left_next;
            refresh_count_reg <= refresh_count_next;
            large_window_reg  <= large_window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (action == ACT_BEGIN))
        begin
            w_reg <= w_next;
            h_reg <= h_next;
        end
    end

endmodule

>>> rtl/wfs_queue.sv
// Small job queue between the front end and the back end.
// Depends on wfs_pkg for the job type.
module wfs_queue
    import wfs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic head_valid,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head       = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/wfs_back.sv
// Back end: expands each queued job into its run of bus bytes and drives
// the registered result channel. Depends on wfs_pkg.
module wfs_back
    import wfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] bus_byte,
    output logic       is_data,
    output logic       wait_busy,
    output logic       last
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] last_step;
    logic              load;
    logic              at_last;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        byte_reg;
    logic              data_reg;
    logic              busy_reg;
    logic              last_reg;
    logic [7:0]        res_byte;
    logic              res_data;
    logic              res_busy;

    assign result_valid = out_valid_reg;
    assign bus_byte     = byte_reg;
    assign is_data      = data_reg;
    assign wait_busy    = busy_reg;
    assign last         = last_reg;

    assign load    = head_valid && (!out_valid_reg || result_ready);
    assign at_last = (step_reg == last_step);
    assign pop     = load && at_last;

    always_comb
    begin
        unique case (head.kind)
            JOB_BEGIN: last_step = STEP_BEGIN_LAST;
            JOB_PIXEL: last_step = head.finish ? STEP_FLUSH_LAST : STEP_FIRST;
            default:   last_step = STEP_FIRST;
        endcase
    end

    always_comb
    begin
        res_byte = head.pixel;
        res_data = 1'b1;
        res_busy = 1'b0;
        if (head.kind == JOB_BEGIN)
        begin
            unique case (step_reg)
                4'd0:    begin res_byte = CMD_RAM_X_RANGE; res_data = 1'b0; end
                4'd1:    res_byte = head.x_start;
                4'd2:    res_byte = head.x_end;
                4'd3:    begin res_byte = CMD_RAM_Y_RANGE; res_data = 1'b0; end
                4'd4:    res_byte = head.y_start_lo;
                4'd5:    res_byte = head.y_start_hi;
                4'd6:    res_byte = head.y_end_lo;
                4'd7:    res_byte = head.y_end_hi;
                4'd8:    begin res_byte = CMD_RAM_X_PTR; res_data = 1'b0; end
                4'd9:    res_byte = head.x_start;
                4'd10:   begin res_byte = CMD_RAM_Y_PTR; res_data = 1'b0; end
                4'd11:   res_byte = head.y_start_lo;
                4'd12:   res_byte = head.y_start_hi;
                default: begin res_byte = CMD_WRITE_RAM; res_data = 1'b0; end
            endcase
        end
        else
        begin
            unique case (step_reg)
                4'd0:    res_byte = head.pixel;
                4'd1:    begin res_byte = CMD_UPDATE_CTRL; res_data = 1'b0; end
                4'd2:    res_byte = head.mode;
                default:
                begin
                    res_byte = CMD_ACTIVATE;
                    res_data = 1'b0;
                    res_busy = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = at_last ? STEP_FIRST : step_reg + STEP_W'(1);
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= res_byte;
            data_reg <= res_data;
            busy_reg <= res_busy;
            last_reg <= at_last;
        end
    end

endmodule

>>> rtl/epaper_window_flush_sequencer.sv
// Top level of the e-paper window flush sequencer.
// Depends on wfs_pkg, wfs_regs, wfs_front, wfs_queue and wfs_back.

// The block turns window-flush items into the command/data byte stream of an
// e-paper controller. A begin item yields a run of 14 bytes (RAM ranges,
// address pointers, write-RAM command); each pixel item yields one data byte,
// and the last pixel byte of a window adds the update-control command, the
// refresh mode byte and the activation command, which carries wait_busy. The
// front end takes one item per clock while the queue has room, except that it
// holds off in the cycle after a begin item while it works out the byte count
// and area with two small multipliers. The back end delivers one result per
// clock through its output register while jobs are queued and the receiver
// takes them; a four-entry job queue lets the two halves stall independently.
// Registers sit on a 32-bit APB port at byte addresses 0x00 to 0x10 and must
// only be written while the block is idle.
module epaper_window_flush_sequencer
    import wfs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  action,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] top_y,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] bottom_y,
    input  logic [7:0]            pixel_byte,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [7:0]            bus_byte,
    output logic                  is_data,
    output logic                  wait_busy,
    output logic                  last
);

    cfg_t cfg;
    job_t push_job;
    job_t head;
    logic push;
    logic pop;
    logic head_valid;
    logic q_full;

    wfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wfs_front #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .action     (action),
        .left_x     (left_x),
        .top_y      (top_y),
        .right_x    (right_x),
        .bottom_y   (bottom_y),
        .pixel_byte (pixel_byte),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    wfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    wfs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .bus_byte     (bus_byte),
        .is_data      (is_data),
        .wait_busy    (wait_busy),
        .last         (last)
    );

endmodule

>>> rtl/wfs_checker.sv
// Port-level checker for the window flush sequencer, bound to the top level.
// Depends on wfs_pkg and epaper_window_flush_sequencer_macros.svh.
`include "epaper_window_flush_sequencer_macros.svh"

module wfs_checker
    import wfs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] bus_byte,
    input logic       is_data,
    input logic       wait_busy,
    input logic       last
);

    logic out_xfer;

    assign out_xfer = result_valid && result_ready;

    // The activation command is always the closing byte of a run.
    `WFS_ASSERT_IMPLY(a_busy_on_activate, clk, rst_n, result_valid && wait_busy, !is_data && bus_byte == CMD_ACTIVATE && last)

    // The write-RAM command closes every begin run.
    `WFS_ASSERT_IMPLY(a_write_ram_last, clk, rst_n, result_valid && !is_data && bus_byte == CMD_WRITE_RAM, last && !wait_busy)

    // The update-control command is followed at once by its mode byte.
    `WFS_ASSERT_NEXT(a_mode_follows, clk, rst_n, out_xfer && !is_data && bus_byte == CMD_UPDATE_CTRL, result_valid && is_data && !last)

    // A stalled result holds its payload.
    `WFS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(bus_byte) && $stable(is_data) && $stable(last))

endmodule

bind epaper_window_flush_sequencer wfs_checker u_wfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .bus_byte     (bus_byte),
    .is_data      (is_data),
    .wait_busy    (wait_busy),
    .last         (last)
);

>>> sim/epaper_window_flush_checker.sv
// Scoreboard for the e-paper window flush sequencer: it follows register
// writes and accepted items, predicts the bus byte stream and checks results.
// Depends on wfs_pkg; the testbench top instantiates it beside the block.
module epaper_window_flush_checker
    import wfs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  logic                  action,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] top_y,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] bottom_y,
    input  logic [7:0]            pixel_byte,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic [7:0]            bus_byte,
    input  logic                  is_data,
    input  logic                  wait_busy,
    input  logic                  last,
    output int unsigned           mismatch_count,
    output int unsigned           bytes_pending,
    output int unsigned           bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       wait_busy;
        logic       last;
    } bus_word_t;

    bus_word_t             due_bytes[$];
    cfg_t                  cfg;
    logic                  flush_open;
    logic [COUNT_BITS-1:0] bytes_remaining;
    logic [7:0]            cheap_refreshes;
    logic                  window_is_large;
    int unsigned           n_mismatch = 0;
    int unsigned           n_checked = 0;

    task automatic add_byte(input logic [7:0] b, input logic data, input logic busy,
                            input logic fin);
        bus_word_t w;
        w.bus_byte  = b;
        w.is_data   = data;
        w.wait_busy = busy;
        w.last      = fin;
        due_bytes.push_back(w);
    endtask

    task automatic flag_error(input string msg);
        n_mismatch++;
        if (n_mismatch <= REPORT_LIMIT)
            $display("%t mismatch: %s", $realtime, msg);
    endtask

    // Expands one accepted item into the bytes it should put on the bus.
    task automatic expand_window_item(input logic act,
                                      input logic [COORD_BITS-1:0] lx,
                                      input logic [COORD_BITS-1:0] ty,
                                      input logic [COORD_BITS-1:0] rx,
                                      input logic [COORD_BITS-1:0] by,
                                      input logic [7:0] pix);
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        int unsigned           w;
        int unsigned           h;
        int unsigned           nbytes;
        int unsigned           area;
        logic [7:0]            mode;
        if (act == ACT_BEGIN) begin
            x0 = lx;
            y0 = ty;
            // Reversed corners collapse the window to a single column or row.
            x1 = (rx < lx) ? lx : rx;
            y1 = (by < ty) ? ty : by;
            w = int'(x1) - int'(x0) + 1;
            h = int'(y1) - int'(y0) + 1;
            nbytes = ((w + 7) / 8) * h;
            if (nbytes > COUNT_MAX)
                nbytes = COUNT_MAX;
            area = w * h;
            add_byte(CMD_RAM_X_RANGE, 1'b0, 1'b0, 1'b0);
            add_byte(8'(x0 >> 3), 1'b1, 1'b0, 1'b0);
            add_byte(8'(x1 >> 3), 1'b1, 1'b0, 1'b0);
            add_byte(CMD_RAM_Y_RANGE, 1'b0, 1'b0, 1'b0);
            add_byte(y0[7:0], 1'b1, 1'b0, 1'b0);
            add_byte(8'(y0 >> 8), 1'b1, 1'b0, 1'b0);
            add_byte(y1[7:0], 1'b1, 1'b0, 1'b0);
            add_byte(8'(y1 >> 8), 1'b1, 1'b0, 1'b0);
            add_byte(CMD_RAM_X_PTR, 1'b0, 1'b0, 1'b0);
            add_byte(8'(x0 >> 3), 1'b1, 1'b0, 1'b0);
            add_byte(CMD_RAM_Y_PTR, 1'b0, 1'b0, 1'b0);
            add_byte(y0[7:0], 1'b1, 1'b0, 1'b0);
            add_byte(8'(y0 >> 8), 1'b1, 1'b0, 1'b0);
            add_byte(CMD_WRITE_RAM, 1'b0, 1'b0, 1'b1);
            flush_open      = 1'b1;
            bytes_remaining = COUNT_BITS'(nbytes);
            window_is_large = (area > cfg.area_threshold);
        end
        else if (flush_open) begin
            if (bytes_remaining != 0)
                bytes_remaining--;
            add_byte(pix, 1'b1, 1'b0, bytes_remaining != 0);
            if (bytes_remaining == 0) begin
                if (cheap_refreshes >= cfg.refresh_limit) begin
                    mode            = cfg.mode_full;
                    cheap_refreshes = '0;
                end
                else begin
                    mode = window_is_large ? cfg.mode_fast : cfg.mode_partial;
                    if (cheap_refreshes != 8'hFF)
                        cheap_refreshes++;
                end
                add_byte(CMD_UPDATE_CTRL, 1'b0, 1'b0, 1'b0);
                add_byte(mode, 1'b1, 1'b0, 1'b0);
                add_byte(CMD_ACTIVATE, 1'b0, 1'b1, 1'b1);
                flush_open      = 1'b0;
                window_is_large = 1'b0;
            end
        end
    endtask

    always @(posedge clk) begin
        bus_word_t want;
        if (!rst_n) begin
            due_bytes.delete();
            cfg.refresh_limit  = RST_REFRESH_LIMIT;
            cfg.area_threshold = RST_AREA_THRESHOLD;
            cfg.mode_full      = RST_MODE_FULL;
            cfg.mode_fast      = RST_MODE_FAST;
            cfg.mode_partial   = RST_MODE_PARTIAL;
            flush_open         = 1'b0;
            bytes_remaining    = '0;
            cheap_refreshes    = '0;
            window_is_large    = 1'b0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_REFRESH_LIMIT:  cfg.refresh_limit  = pwdata[7:0];
                    REG_AREA_THRESHOLD: cfg.area_threshold = pwdata[THR_W-1:0];
                    REG_MODE_FULL:      cfg.mode_full      = pwdata[7:0];
                    REG_MODE_FAST:      cfg.mode_fast      = pwdata[7:0];
                    REG_MODE_PARTIAL:   cfg.mode_partial   = pwdata[7:0];
                    default: ;
                endcase
            end
            // Results are retired before new items are expanded, so a result
            // can never be matched against an item accepted at the same edge.
            if (result_valid && result_ready) begin
                n_checked++;
                if (due_bytes.size() == 0) begin
                    flag_error($sformatf("unexpected result byte %02h data %0b busy %0b last %0b",
                                         bus_byte, is_data, wait_busy, last));
                end
                else begin
                    want = due_bytes.pop_front();
                    if (bus_byte !== want.bus_byte || is_data !== want.is_data ||
                        wait_busy !== want.wait_busy || last !== want.last)
                        flag_error($sformatf({"result %0d: expected byte %02h data %0b ",
                                              "busy %0b last %0b, got %02h %0b %0b %0b"},
                                             n_checked, want.bus_byte, want.is_data,
                                             want.wait_busy, want.last, bus_byte,
                                             is_data, wait_busy, last));
                end
            end
            if (item_valid && item_ready)
                expand_window_item(action, left_x, top_y, right_x, bottom_y, pixel_byte);
        end
        mismatch_count <= n_mismatch;
        bytes_pending  <= due_bytes.size();
        bytes_checked  <= n_checked;
    end

endmodule

>>> sim/tb_epaper_window_flush_sequencer.sv
// Testbench top for the e-paper window flush sequencer: clock, reset, register
// writes, bursty item traffic, a stalling receiver and the final verdict.
// Depends on wfs_pkg, the block's RTL and epaper_window_flush_checker.
module tb_epaper_window_flush_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import wfs_pkg::*;

    localparam int       CB           = COORD_BITS_DEFAULT;
    localparam int       MAX_COORD    = (1 << CB) - 1;
    localparam int       RANDOM_ITEMS = 150;
    localparam int       PHASES       = 6;
    localparam int       DRAIN_CYCLES = 32;
    localparam longint   TIMEOUT_NS   = 2_000_000;
    localparam reg_idx_t REG_UNMAPPED = reg_idx_t'(3'd6);

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_CHOPPY,
        RX_TRICKLE
    } rx_style_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid = 1'b0;
    logic              item_ready;
    logic              action = ACT_BEGIN;
    logic [CB-1:0]     left_x = '0;
    logic [CB-1:0]     top_y = '0;
    logic [CB-1:0]     right_x = '0;
    logic [CB-1:0]     bottom_y = '0;
    logic [7:0]        pixel_byte = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [7:0]        bus_byte;
    logic              is_data;
    logic              wait_busy;
    logic              last;

    int unsigned       mismatch_count;
    int unsigned       bytes_pending;
    int unsigned       bytes_checked;

    int unsigned       items_sent = 0;
    int unsigned       strays_sent = 0;
    int unsigned       settings_used = 1;
    int unsigned       burst_left = 0;
    bit                window_open = 1'b0;
    rx_style_t         rx_mode = RX_STREAM;
    int unsigned       rx_span = 0;

    epaper_window_flush_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .left_x       (left_x),
        .top_y        (top_y),
        .right_x      (right_x),
        .bottom_y     (bottom_y),
        .pixel_byte   (pixel_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .bus_byte     (bus_byte),
        .is_data      (is_data),
        .wait_busy    (wait_busy),
        .last         (last)
    );

    epaper_window_flush_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .action         (action),
        .left_x         (left_x),
        .top_y          (top_y),
        .right_x        (right_x),
        .bottom_y       (bottom_y),
        .pixel_byte     (pixel_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .bus_byte       (bus_byte),
        .is_data        (is_data),
        .wait_busy      (wait_busy),
        .last           (last),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending),
        .bytes_checked  (bytes_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver switches between streaming, choppy and trickling stretches.
    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode <= rx_style_t'(2'($urandom_range(0, 2)));
            rx_span <= $urandom_range(4, 60);
        end
        else
        begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_STREAM:  result_ready <= 1'b1;
            RX_CHOPPY:  result_ready <= 1'($urandom_range(0, 1));
            RX_TRICKLE: result_ready <= ($urandom_range(0, 3) == 0);
            default:    result_ready <= 1'b1;
        endcase
    end

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] limit, input logic [THR_W-1:0] threshold,
                                input logic [7:0] full, input logic [7:0] fast,
                                input logic [7:0] partial);
        write_reg(REG_UNMAPPED, $urandom);
        write_reg(REG_REFRESH_LIMIT, DATA_W'(limit));
        write_reg(REG_AREA_THRESHOLD, DATA_W'(threshold));
        write_reg(REG_MODE_FULL, DATA_W'(full));
        write_reg(REG_MODE_FAST, DATA_W'(fast));
        write_reg(REG_MODE_PARTIAL, DATA_W'(partial));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Valid stays high across a burst; a gap only starts when a burst runs out.
    task automatic offer_item(input logic act, input logic [CB-1:0] lx, input logic [CB-1:0] ty,
                              input logic [CB-1:0] rx, input logic [CB-1:0] by,
                              input logic [7:0] pix);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        item_valid <= 1'b1;
        action     <= act;
        left_x     <= lx;
        top_y      <= ty;
        right_x    <= rx;
        bottom_y   <= by;
        pixel_byte <= pix;
        @(posedge clk iff item_ready);
        items_sent++;
    endtask

    task automatic send_begin(input logic [CB-1:0] lx, input logic [CB-1:0] ty,
                              input logic [CB-1:0] rx, input logic [CB-1:0] by);
        offer_item(ACT_BEGIN, lx, ty, rx, by, 8'($urandom));
    endtask

    task automatic send_pixel(input logic [7:0] pix);
        offer_item(ACT_PIXEL, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), pix);
    endtask

    // Opens a random window and sends either all of its bytes or only a part,
    // leaving it open for the next begin to abandon.
    task automatic random_window(input bit complete);
        logic [CB-1:0] lx;
        logic [CB-1:0] ty;
        logic [CB-1:0] rx;
        logic [CB-1:0] by;
        int unsigned   w;
        int unsigned   h;
        int unsigned   n;
        lx = CB'($urandom);
        ty = CB'($urandom);
        if ($urandom_range(0, 5) == 0)
        begin
            w = $urandom_range(64, 300);
            h = 1;
        end
        else
        begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 4);
        end
        rx = (int'(lx) + w - 1 > MAX_COORD) ? CB'(MAX_COORD) : CB'(int'(lx) + w - 1);
        by = (int'(ty) + h - 1 > MAX_COORD) ? CB'(MAX_COORD) : CB'(int'(ty) + h - 1);
        if ($urandom_range(0, 9) == 0)
            rx = CB'($urandom_range(0, lx));
        if ($urandom_range(0, 9) == 0)
            by = CB'($urandom_range(0, ty));
        w = (rx >= lx) ? int'(rx) - int'(lx) + 1 : 1;
        h = (by >= ty) ? int'(by) - int'(ty) + 1 : 1;
        n = ((w + 7) / 8) * h;
        send_begin(lx, ty, rx, by);
        if (!complete)
            n = $urandom_range(0, n - 1);
        repeat (n) send_pixel(8'($urandom));
        window_open = !complete;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (bytes_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned goal;
        int unsigned pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values first. A pixel with no window open is ignored.
        send_pixel(8'hA5);
        strays_sent++;
        // Reversed corners at the far edge collapse to one pixel: one byte.
        send_begin(CB'(MAX_COORD), CB'(MAX_COORD), '0, '0);
        send_pixel(8'hFF);
        send_begin('0, '0, CB'(7), '0);
        send_pixel(8'h00);
        // The full panel overflows the byte counter and is large; it is then
        // abandoned by a new begin after a few bytes.
        send_begin('0, '0, CB'(MAX_COORD), CB'(MAX_COORD));
        send_pixel(8'h55);
        send_pixel(8'hAA);
        send_pixel(8'hFF);
        send_begin(CB'(1016), CB'(1020), CB'(MAX_COORD), CB'(MAX_COORD));
        send_pixel(8'h01);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        send_pixel(8'hFE);
        // Rows straddle 256, so the high byte of the Y range changes.
        send_begin(CB'(513), CB'(255), CB'(520), CB'(256));
        send_pixel(8'h3C);
        send_pixel(8'hC3);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: apply_config(8'd0, '0, 8'h00, 8'hFF, 8'($urandom));
                1: apply_config(8'd1, THR_W'(1 << 20), 8'hFF, 8'h00, 8'h00);
                2: apply_config(8'd255, '0, 8'($urandom), 8'($urandom), 8'($urandom));
                default: apply_config(8'($urandom_range(1, 8)),
                                      THR_W'($urandom_range(0, 400)),
                                      8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            goal = (p + 1) * RANDOM_ITEMS / PHASES;
            while (items_sent - strays_sent < goal)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                begin
                    random_window(1'b1);
                end
                else if (pick < 18)
                begin
                    random_window(1'b0);
                end
                else if (!window_open)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_pixel(8'($urandom));
                        strays_sent++;
                    end
                end
            end
        end

        wait_idle();
        $display("Run covered %0d input transactions (%0d with no window open) under %0d",
                 items_sent, strays_sent, settings_used);
        $display("register settings, with %0d result transactions checked.", bytes_checked);
        if (mismatch_count == 0)
            $display("tb_epaper_window_flush_sequencer: clean");
        else
            $display("tb_epaper_window_flush_sequencer: errors");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still expected.", bytes_pending);
        $display("tb_epaper_window_flush_sequencer: errors");
        $finish;
    end

endmodule
